// ===== sv/sukt_pkg.sv =====
package sukt_pkg;

   localparam int KEY_W    = 34;
   localparam int REQ_PAY_W = 32;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 8;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_SEARCH = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_FOUND     = 3'd5,
      ST_CLEARED   = 3'd6
   } status_type;

   typedef struct packed {
      req_code_type          req_type;
      logic [KEY_W-1:0]      entry_key;
      logic [REQ_PAY_W-1:0]  entry_payload;
   } req_word_type;

   typedef struct packed {
      status_type            status;
      logic [REQ_PAY_W-1:0]  found_payload;
      logic [POS_W-1:0]      position;
      logic [COUNT_W-1:0]    entry_count;
   } rsp_word_type;

endpackage

// ===== sv/sorted_unique_key_table_core.sv =====
// steps: an accept step, then binary search probes (ceil(log2(count+1)) probes), each a read
// and a compare, then a decision step, then the shift moves, plus one write for insert,
// and a load of the result register; clear goes from the accept step straight to the result load
// the shift is paced by the one read port and the one write port of the entry memory;
// one request at a time, the next is taken once the result is queued
// reset clears the sequencer, the entry count and the result valid; the entry memory is not swept
module sorted_unique_key_table_core #(
   parameter int CAPACITY     = 128,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sukt_pkg::req_word_type      req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sukt_pkg::rsp_word_type      rsp_word
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_CHECK,
      S_SHIFT,
      S_PLACE,
      S_RESP
   } state_type;

   // entry memory
   logic [sukt_pkg::KEY_W-1:0] key_mem [CAPACITY];
   logic [PAYLOAD_BITS-1:0]    pay_mem [CAPACITY];
   logic [sukt_pkg::KEY_W-1:0] rd_key_ff;
   logic [PAYLOAD_BITS-1:0]    rd_pay_ff;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [sukt_pkg::KEY_W-1:0] wr_key;
   logic [PAYLOAD_BITS-1:0]    wr_pay;

   // sequencer
   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   sukt_pkg::req_code_type     op_ff, op_in;
   logic [sukt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]    pay_ff, pay_in;
   logic [CNT_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]           hi_ff, hi_in;
   logic [ADDR_W-1:0]          mid_ff, mid_in;
   logic                       eq_ff, eq_in;
   logic [PAYLOAD_BITS-1:0]    hit_pay_ff, hit_pay_in;
   logic [ADDR_W-1:0]          sp_ff, sp_in;
   logic [ADDR_W-1:0]          last_ff, last_in;
   logic                       more_ff, more_in;
   logic                       mv_pend_ff, mv_pend_in;
   logic [ADDR_W-1:0]          mv_dst_ff, mv_dst_in;
   sukt_pkg::status_type       res_status_ff, res_status_in;
   logic [CNT_W-1:0]           res_pos_ff, res_pos_in;
   logic [PAYLOAD_BITS-1:0]    res_pay_ff, res_pay_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   sukt_pkg::rsp_word_type     rsp_word_ff, rsp_word_in;

   logic [CNT_W:0]             mid_sum;
   logic [ADDR_W-1:0]          mid_calc;
   logic                       rsp_free;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = ADDR_W'(mid_sum >> 1);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      eq_in         = eq_ff;
      hit_pay_in    = hit_pay_ff;
      sp_in         = sp_ff;
      last_in       = last_ff;
      more_in       = more_ff;
      mv_pend_in    = 1'b0;
      mv_dst_in     = mv_dst_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      rd_addr       = mid_calc;
      wr_en         = 1'b0;
      wr_addr       = ADDR_W'(lo_ff);
      wr_key        = key_ff;
      wr_pay        = pay_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_word.req_type;
               key_in     = req_word.entry_key;
               pay_in     = PAYLOAD_BITS'(req_word.entry_payload);
               lo_in      = '0;
               hi_in      = count_ff;
               eq_in      = 1'b0;
               res_pos_in = '0;
               res_pay_in = '0;
               if (req_word.req_type == sukt_pkg::REQ_CLEAR) begin
                  count_in      = '0;
                  res_status_in = sukt_pkg::ST_CLEARED;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end

         S_PROBE: begin
            if (lo_ff != hi_ff) begin
               mid_in   = mid_calc;
               state_in = S_CHECK;
            end else begin
               // search done, lo is the first entry whose key is not above the request key
               unique case (op_ff)
                  sukt_pkg::REQ_INSERT: begin
                     if (eq_ff) begin
                        wr_en         = 1'b1;
                        res_status_in = sukt_pkg::ST_UPDATED;
                        res_pos_in    = lo_ff;
                        state_in      = S_RESP;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = sukt_pkg::ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        sp_in         = ADDR_W'(count_ff - CNT_W'(1));
                        last_in       = ADDR_W'(lo_ff);
                        more_in       = (lo_ff != count_ff);
                        res_status_in = sukt_pkg::ST_INSERTED;
                        res_pos_in    = lo_ff;
                        state_in      = S_SHIFT;
                     end
                  end
                  sukt_pkg::REQ_REMOVE: begin
                     if (eq_ff) begin
                        sp_in         = ADDR_W'(lo_ff + CNT_W'(1));
                        last_in       = ADDR_W'(count_ff - CNT_W'(1));
                        more_in       = (({1'b0, lo_ff} + (CNT_W+1)'(1)) < {1'b0, count_ff});
                        count_in      = count_ff - CNT_W'(1);
                        res_status_in = sukt_pkg::ST_REMOVED;
                        res_pos_in    = lo_ff;
                        state_in      = S_SHIFT;
                     end else begin
                        res_status_in = sukt_pkg::ST_NOT_FOUND;
                        state_in      = S_RESP;
                     end
                  end
                  default: begin
                     if (eq_ff) begin
                        res_status_in = sukt_pkg::ST_FOUND;
                        res_pay_in    = hit_pay_ff;
                        res_pos_in    = lo_ff;
                     end else begin
                        res_status_in = sukt_pkg::ST_NOT_FOUND;
                     end
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_CHECK: begin
            // keys descend, so a stored key at or below the request moves the upper bound
            if (rd_key_ff <= key_ff) begin
               hi_in = CNT_W'(mid_ff);
               eq_in = (rd_key_ff == key_ff);
               if (rd_key_ff == key_ff) begin
                  hit_pay_in = rd_pay_ff;
               end
            end else begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end
            state_in = S_PROBE;
         end

         S_SHIFT: begin
            // one read issued per cycle, its word written one place over on the next
            rd_addr = sp_ff;
            if (mv_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = mv_dst_ff;
               wr_key  = rd_key_ff;
               wr_pay  = rd_pay_ff;
            end
            if (more_ff) begin
               mv_pend_in = 1'b1;
               more_in    = (sp_ff != last_ff);
               if (op_ff == sukt_pkg::REQ_INSERT) begin
                  mv_dst_in = sp_ff + ADDR_W'(1);
                  sp_in     = sp_ff - ADDR_W'(1);
               end else begin
                  mv_dst_in = sp_ff - ADDR_W'(1);
                  sp_in     = sp_ff + ADDR_W'(1);
               end
            end else if (!mv_pend_ff) begin
               state_in = (op_ff == sukt_pkg::REQ_INSERT) ? S_PLACE : S_RESP;
            end
         end

         S_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.status        = res_status_ff;
               rsp_word_in.found_payload = sukt_pkg::REQ_PAY_W'(res_pay_ff);
               rsp_word_in.position      = sukt_pkg::POS_W'(res_pos_ff);
               rsp_word_in.entry_count   = sukt_pkg::COUNT_W'(count_ff);
               state_in                  = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mv_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         mv_pend_ff   <= mv_pend_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      eq_ff         <= eq_in;
      hit_pay_ff    <= hit_pay_in;
      sp_ff         <= sp_in;
      last_ff       <= last_in;
      more_ff       <= more_in;
      mv_dst_ff     <= mv_dst_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_pay_ff    <= res_pay_in;
      rsp_word_ff   <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_pay;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_pay_ff <= pay_mem[rd_addr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ({1'b0, mid_ff} < (ADDR_W+1)'(count_ff)))
      else $error("search probe outside held entries");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < (ADDR_W+1)'(CAPACITY)))
      else $error("entry write beyond capacity");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result word raised outside response step");

endmodule
